>>> design/bfa_pkg.sv
// Shared types, constants and helper functions of the bitmap allocator.
package bfa_pkg;

   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 6;
   localparam int NUM_W   = 9;
   localparam int POS_W   = 3;

   localparam logic [BYTE_W-1:0] BYTE_FULL = 8'hFF;

   // Request codes
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_LOAD  = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } bfa_state_type;

   typedef struct packed {
      logic             granted;
      logic [NUM_W-1:0] alloc_number;
   } bfa_res_type;

   // Position of the first clear bit counted from the MSB (0 = bit 7).
   function automatic logic [POS_W-1:0] first_zero(input logic [BYTE_W-1:0] b);
      logic [POS_W-1:0] pos;
      pos = '0;
      for (int j = 0; j < BYTE_W; j++) begin
         if (!b[j]) begin
            pos = POS_W'(BYTE_W - 1 - j);
         end
      end
      return pos;
   endfunction

   // One-hot mask of the bit at MSB-relative position pos.
   function automatic logic [BYTE_W-1:0] bit_mask(input logic [POS_W-1:0] pos);
      logic [BYTE_W-1:0] m;
      m = 8'h80 >> pos;
      return m;
   endfunction

endpackage

>>> design/bfa_ifs.sv
// Request and response channel interfaces of the bitmap allocator.
interface bfa_req_if import bfa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [INDEX_W-1:0] byte_index;
   logic [BYTE_W-1:0]  byte_value;

   modport source (output valid, output req_type, output byte_index, output byte_value,
                   input ready);
   modport sink   (input valid, input req_type, input byte_index, input byte_value,
                   output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             granted;
   logic [NUM_W-1:0] alloc_number;

   modport source (output valid, output granted, output alloc_number, input ready);
   modport sink   (input valid, input granted, input alloc_number, output ready);
endinterface

>>> design/bitmap_first_free_allocator.sv
// Top level of the bitmap first-free allocator: sequencer, map store, output register.
//
// Request channel (req_chan): one word per request. req_type REQ_ALLOC takes the
// first clear bit of the map (bytes from index 0 up, bits from the MSB down), sets
// it and answers granted = 1 with alloc_number = 8*byte + bit; a full map answers
// granted = 0, number 0. req_type REQ_LOAD overwrites byte byte_index with
// byte_value and answers granted = 1 (granted = 0 if the index lies beyond the map).
// Response channel (rsp_chan): exactly one word per request, in request order.
// An allocation reads one map byte per cycle from the single read port, from byte 0
// up to the byte that holds the free bit, or through the whole map when it is full.
// One request is in flight at a time; the next is taken once the answer has moved
// to the output register.
// Reset: the map is cleared by a sweep over every byte, one byte a cycle; the
// request channel is held not ready until it completes.
// A stalled receiver holds the answer in the output register; one further request
// may be accepted and worked, its answer waiting in the sequencer until the slot frees.
module bitmap_first_free_allocator import bfa_pkg::*; #(
   parameter int MAP_BYTES = 64
) (
   input  logic       clock,
   input  logic       reset,
   bfa_req_if.sink    req_chan,
   bfa_rsp_if.source  rsp_chan
);

   localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

   logic              slot_free;
   logic              res_valid;
   bfa_res_type       res;

   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [BYTE_W-1:0] mem_wr_data;
   logic [AW-1:0]     mem_rd_addr;
   logic [BYTE_W-1:0] mem_rd_data;

   // output register: decouples the receiver's stall from the sequencer
   logic              rsp_valid_ff, rsp_valid_in;
   bfa_res_type       rsp_res_ff;

   bfa_ctrl #(
      .MAP_BYTES (MAP_BYTES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .slot_free   (slot_free),
      .res_valid   (res_valid),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   bfa_map_ram #(
      .DEPTH (MAP_BYTES)
   ) u_map (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // slot can take a word when empty or being drained this cycle
   assign slot_free    = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && slot_free) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.granted      = rsp_res_ff.granted;
   assign rsp_chan.alloc_number = rsp_res_ff.alloc_number;

endmodule

>>> design/bfa_map_ram.sv
// Occupancy bitmap store: one write port, one read port, registered read data.
module bfa_map_ram import bfa_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [BYTE_W-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [BYTE_W-1:0]                        rd_data
);

   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/bfa_ctrl.sv
// Sequencer: clearing sweep, byte loads and the first-free scan over the map.
module bfa_ctrl import bfa_pkg::*; #(
   parameter int MAP_BYTES = 64
) (
   input  logic                clock,
   input  logic                reset,
   bfa_req_if.sink             req_chan,
   input  logic                slot_free,
   output logic                res_valid,
   output bfa_res_type         res,
   output logic                mem_wr_en,
   output logic [((MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1)-1:0] mem_wr_addr,
   output logic [BYTE_W-1:0]   mem_wr_data,
   output logic [((MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1)-1:0] mem_rd_addr,
   input  logic [BYTE_W-1:0]   mem_rd_data
);

   localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(MAP_BYTES - 1);

   bfa_state_type     state_ff, state_in;
   logic [AW-1:0]     idx_ff, idx_in;
   bfa_res_type       res_ff, res_in;

   logic              accept;
   logic              load_hit;
   logic              free_found;
   logic              at_last;
   logic [POS_W-1:0]  pos;
   logic [AW+5:0]     ld_ext;
   logic [AW+8:0]     num_ext;

   assign accept     = req_chan.valid && req_chan.ready;
   assign load_hit   = 32'(req_chan.byte_index) < 32'(MAP_BYTES);
   assign free_found = mem_rd_data != BYTE_FULL;
   assign at_last    = idx_ff == LAST_IDX;
   assign pos        = first_zero(mem_rd_data);
   assign ld_ext     = {AW'(0), req_chan.byte_index};
   assign num_ext    = {6'd0, idx_ff, pos};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (at_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_chan.req_type == REQ_LOAD) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (free_found || at_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      mem_wr_en      = 1'b0;
      mem_wr_addr    = idx_ff;
      mem_wr_data    = '0;
      mem_rd_addr    = idx_ff + AW'(1);
      idx_in         = idx_ff;
      res_in         = res_ff;
      req_chan.ready = 1'b0;
      res_valid      = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
            idx_in    = at_last ? '0 : idx_ff + AW'(1);
         end
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            mem_rd_addr    = '0;
            idx_in         = '0;
            if (accept && req_chan.req_type == REQ_LOAD) begin
               mem_wr_en    = load_hit;
               mem_wr_addr  = ld_ext[AW-1:0];
               mem_wr_data  = req_chan.byte_value;
               res_in.granted      = load_hit;
               res_in.alloc_number = '0;
            end
         end
         ST_SCAN: begin
            if (free_found) begin
               mem_wr_en           = 1'b1;
               mem_wr_data         = mem_rd_data | bit_mask(pos);
               res_in.granted      = 1'b1;
               res_in.alloc_number = num_ext[NUM_W-1:0];
            end else if (at_last) begin
               res_in.granted      = 1'b0;
               res_in.alloc_number = '0;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res = res_ff;

   // a byte with a clear bit ends the scan with a grant
   a_scan_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && mem_rd_data != BYTE_FULL)
      |=> (state_ff == ST_DONE && res_ff.granted))
      else $error("scan hit did not end in a grant");

   // a finished result waits untouched until the output slot takes it
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !slot_free) |=> (state_ff == ST_DONE && $stable(res_ff)))
      else $error("pending result changed while output slot busy");

   // refused results (full map or load beyond the map) carry number zero
   a_zero_number: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !res_ff.granted) |-> (res_ff.alloc_number == '0))
      else $error("non-granted result carries a number");

endmodule
